/* hdl/pli_pkg.sv */
package pli_pkg;

    // input item codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FLAT = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE = 1'd1;

    // shared unit step counts
    localparam int STEP_W    = 6;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 64;

    // saturation bounds on the wide result
    localparam logic signed [41:0] RES_MAX = 42'sh0_7FFF_FFFF;
    localparam logic signed [41:0] RES_MIN = -42'sh0_8000_0000;

    typedef struct packed {
        logic              cmd;
        logic [3:0]        point_slot;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] interpolated;
        logic [1:0]         status;
    } out_rsp_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* hdl/piecewise_linear_interpolator_core.sv */
// sequence: a load request is written to the table as it is accepted; an evaluate
//   request scans the table up to the segment end point index k (1 .. point count - 1),
//   then runs the multiply and divide; a flat segment skips the multiply and divide
// throughput: one request at a time, set by the 32-step multiply and 64-step divide
//   of the shared shift/add unit and the one-entry-per-cycle table scan
// reset: aresetn synchronous active low; point_count 2, mirror_mode 0, table undefined
module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pli_pkg::in_req_t                  s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output pli_pkg::out_rsp_t                 m_data,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [pli_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pli_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    // wide enough for the 5-bit count register and for MAX_POINTS itself
    localparam int CNT_W = ($clog2(MAX_POINTS + 1) > 5) ? $clog2(MAX_POINTS + 1) : 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREV,
        S_SCAN,
        S_SETUP,
        S_LAUNCH,
        S_MUL,
        S_DIV,
        S_SUM,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [4:0] point_count_reg;
    logic       mirror_mode_reg;

    // request context
    logic signed [32:0] q_reg;
    logic               neg_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic [IDX_W-1:0]   idx_reg;

    // segment end points and differences
    logic signed [31:0] x0_reg;
    logic signed [31:0] y0_reg;
    logic signed [31:0] x1_reg;
    logic signed [31:0] y1_reg;
    logic signed [32:0] dx_reg;
    logic signed [33:0] dv_reg;
    logic signed [32:0] dy_reg;
    logic               flat_reg;
    logic signed [41:0] sum_reg;

    // output register
    logic               m_valid_reg;
    pli_pkg::out_rsp_t  m_data_reg;

    // table port
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_rd_addr;
    pli_pkg::point_t  tbl_rd_data;
    pli_pkg::point_t  tbl_wr_data;

    // shared unit
    pli_pkg::unit_cmd_t  unit_cmd;
    pli_pkg::unit_stat_t unit_stat;
    logic [63:0]         unit_result;
    logic [32:0]         dv_mag;
    logic [31:0]         dy_mag;
    logic [31:0]         dx_mag;

    logic               s_fire;
    logic               out_free;
    logic [CNT_W-1:0]   cnt_ext;
    logic [CNT_W-1:0]   len;
    logic [IDX_W-1:0]   last_idx;
    logic signed [32:0] q_in;
    logic               scan_go;
    logic               dx_zero;
    logic               quo_big;
    logic [40:0]        quo;
    logic               res_sign;
    logic signed [41:0] y0_ext;
    logic signed [41:0] quo_ext;
    logic signed [41:0] fin;
    logic               fin_hi;
    logic               fin_lo;
    logic signed [31:0] fin_clamped;
    logic [1:0]         fin_status;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // point count used as 2 .. MAX_POINTS
    always_comb begin
        cnt_ext = CNT_W'(point_count_reg);
        if (cnt_ext < CNT_W'(2)) begin
            len = CNT_W'(2);
        end else if (cnt_ext > CNT_W'(MAX_POINTS)) begin
            len = CNT_W'(MAX_POINTS);
        end else begin
            len = cnt_ext;
        end
        last_idx = IDX_W'(len - CNT_W'(1));
    end

    // mirror mode folds a negative query onto the positive side
    always_comb begin
        q_in = {s_data.query[31], s_data.query};
        if (mirror_mode_reg && s_data.query[31]) begin
            q_in = -q_in;
        end
    end

    // loads go straight to the table, slots past the table are dropped
    assign tbl_wr_en   = s_fire && (s_data.cmd == pli_pkg::CMD_LOAD)
                         && (32'(s_data.point_slot) < MAX_POINTS);
    assign tbl_wr_data = '{x: s_data.point_x, y: s_data.point_y};

    // read address one step ahead of the scan
    always_comb begin
        unique case (state_reg)
            S_PREV:  tbl_rd_addr = idx_reg;
            S_SCAN:  tbl_rd_addr = idx_reg + 1'b1;
            default: tbl_rd_addr = '0;
        endcase
    end

    // keep walking while below the last point and the table x is under the query
    assign scan_go = (idx_reg < last_idx_reg)
                     && ($signed({tbl_rd_data.x[31], tbl_rd_data.x}) < q_reg);

    // magnitudes for the unsigned shift/add unit
    assign dv_mag  = dv_reg[33] ? 33'(-dv_reg) : dv_reg[32:0];
    assign dy_mag  = dy_reg[32] ? 32'(-dy_reg) : dy_reg[31:0];
    assign dx_mag  = dx_reg[32] ? 32'(-dx_reg) : dx_reg[31:0];
    assign dx_zero = (dx_reg == '0);

    always_comb begin
        unit_cmd = '{start: 1'b0, op: pli_pkg::OP_MUL};
        if (state_reg == S_LAUNCH && !dx_zero) begin
            unit_cmd = '{start: 1'b1, op: pli_pkg::OP_MUL};
        end else if (state_reg == S_MUL && unit_stat.done) begin
            unit_cmd = '{start: 1'b1, op: pli_pkg::OP_DIV};
        end
    end

    // quotient clamped to 2^40, sign from the three differences
    always_comb begin
        quo_big = (|unit_result[63:41]) || (unit_result[40] && (|unit_result[39:0]));
        if (flat_reg) begin
            quo = '0;
        end else if (quo_big) begin
            quo = 41'h100_0000_0000;
        end else begin
            quo = unit_result[40:0];
        end
        res_sign = dv_reg[33] ^ dy_reg[32] ^ dx_reg[32];
        y0_ext   = {{10{y0_reg[31]}}, y0_reg};
        quo_ext  = $signed({1'b0, quo});
    end

    // final negate for mirror mode and 32-bit saturation
    always_comb begin
        fin    = neg_reg ? -sum_reg : sum_reg;
        fin_hi = (fin > pli_pkg::RES_MAX);
        fin_lo = (fin < pli_pkg::RES_MIN);
        if (fin_hi) begin
            fin_clamped = 32'sh7FFF_FFFF;
        end else if (fin_lo) begin
            fin_clamped = 32'sh8000_0000;
        end else begin
            fin_clamped = fin[31:0];
        end
        if (flat_reg) begin
            fin_status = pli_pkg::ST_FLAT;
        end else if (fin_hi || fin_lo) begin
            fin_status = pli_pkg::ST_SAT;
        end else begin
            fin_status = pli_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            point_count_reg <= 5'd2;
            mirror_mode_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            idx_reg         <= '0;
            last_idx_reg    <= '0;
            neg_reg         <= 1'b0;
            flat_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    pli_pkg::REG_POINT_COUNT: point_count_reg <= cfg_wdata;
                    pli_pkg::REG_MIRROR_MODE: mirror_mode_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            // in S_DONE the output register is reloaded or held by the state itself
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && s_data.cmd == pli_pkg::CMD_EVAL) begin
                        q_reg        <= q_in;
                        neg_reg      <= mirror_mode_reg && s_data.query[31];
                        last_idx_reg <= last_idx;
                        idx_reg      <= IDX_W'(1);
                        state_reg    <= S_PREV;
                    end
                end
                S_PREV: begin
                    // entry 0 arrives here
                    x0_reg    <= tbl_rd_data.x;
                    y0_reg    <= tbl_rd_data.y;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_go) begin
                        x0_reg  <= tbl_rd_data.x;
                        y0_reg  <= tbl_rd_data.y;
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        x1_reg    <= tbl_rd_data.x;
                        y1_reg    <= tbl_rd_data.y;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    dx_reg    <= {x1_reg[31], x1_reg} - {x0_reg[31], x0_reg};
                    dv_reg    <= {q_reg[32], q_reg} - {{2{x0_reg[31]}}, x0_reg};
                    dy_reg    <= {y1_reg[31], y1_reg} - {y0_reg[31], y0_reg};
                    state_reg <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    // flat segment skips the multiply and divide
                    flat_reg  <= dx_zero;
                    state_reg <= dx_zero ? S_SUM : S_MUL;
                end
                S_MUL: begin
                    if (unit_stat.done) begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (unit_stat.done) begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    sum_reg   <= res_sign ? (y0_ext - quo_ext) : (y0_ext + quo_ext);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // wait for the output register to free up
                    if (out_free) begin
                        m_data_reg  <= '{interpolated: fin_clamped, status: fin_status};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    pli_table #(
        .DEPTH(MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (IDX_W'(s_data.point_slot)),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    pli_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (unit_cmd),
        .mcand   (dv_mag),
        .mplier  (dy_mag),
        .divisor (dx_mag),
        .stat    (unit_stat),
        .result  (unit_result)
    );

`ifndef SYNTHESIS
    // the shared unit is never restarted while it is stepping
    assert property (@(posedge aclk) disable iff (!aresetn)
        unit_cmd.start |-> !unit_stat.busy)
        else $error("shared unit started while busy");

    // an evaluate request blocks the request channel on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.cmd == pli_pkg::CMD_EVAL) |=> !s_ready)
        else $error("request channel open during evaluate");

    // the scan never runs past the last point in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (idx_reg <= last_idx_reg))
        else $error("scan index past last point");

    // unit completion only shows up while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        unit_stat.done |-> (state_reg == S_MUL || state_reg == S_DIV))
        else $error("unit done outside wait state");

    // the output register is only loaded when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=> (state_reg == S_DONE))
        else $error("result dropped on a stalled output");
`endif

endmodule

/* hdl/pli_table.sv */
module pli_table #(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  pli_pkg::point_t          wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output pli_pkg::point_t          rd_data
);

    pli_pkg::point_t mem [DEPTH];
    pli_pkg::point_t rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/pli_muldiv.sv */
module pli_muldiv (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pli_pkg::unit_cmd_t    cmd,
    input  logic [32:0]           mcand,
    input  logic [31:0]           mplier,
    input  logic [31:0]           divisor,
    output pli_pkg::unit_stat_t   stat,
    output logic [63:0]           result
);

    pli_pkg::unit_op_t           op_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [pli_pkg::STEP_W-1:0]  cnt_reg;
    logic [65:0]                 work_reg;
    logic [31:0]                 rem_reg;
    logic [32:0]                 opnd_reg;

    logic [33:0] opa;
    logic [33:0] opb;
    logic [33:0] sum;
    logic        cin;
    logic        ge;

    // single adder: shift-add for multiply, trial subtract for divide
    always_comb begin
        if (op_reg == pli_pkg::OP_MUL) begin
            opa = work_reg[65:32];
            opb = work_reg[0] ? {1'b0, opnd_reg} : 34'd0;
            cin = 1'b0;
        end else begin
            opa = {1'b0, rem_reg, work_reg[63]};
            opb = ~{1'b0, opnd_reg};
            cin = 1'b1;
        end
        sum = opa + opb + {33'd0, cin};
        ge  = ~sum[33];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= pli_pkg::OP_MUL;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                op_reg   <= cmd.op;
                busy_reg <= 1'b1;
                cnt_reg  <= (cmd.op == pli_pkg::OP_MUL)
                            ? pli_pkg::STEP_W'(pli_pkg::MUL_STEPS - 1)
                            : pli_pkg::STEP_W'(pli_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            if (cmd.op == pli_pkg::OP_MUL) begin
                work_reg <= {34'd0, mplier};
                opnd_reg <= mcand;
            end else begin
                // dividend is the product left by the multiply
                work_reg <= {2'b00, work_reg[63:0]};
                rem_reg  <= '0;
                opnd_reg <= {1'b0, divisor};
            end
        end else if (busy_reg) begin
            if (op_reg == pli_pkg::OP_MUL) begin
                work_reg <= {1'b0, sum, work_reg[31:1]};
            end else begin
                rem_reg  <= ge ? sum[31:0] : {rem_reg[30:0], work_reg[63]};
                work_reg <= {2'b00, work_reg[62:0], ge};
            end
        end
    end

    assign stat   = '{busy: busy_reg, done: done_reg};
    assign result = work_reg[63:0];

endmodule
